// File: rtl/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants of the source byte tokenizer
// Result kinds, token types, character codes and the result word layout.
// ----------------------------------------------------------------------------
package sbt_pkg;

    // Longest token that is kept before an overflow error
    localparam logic [6:0]  MAX_TOKEN_LEN = 7'd64;
    localparam logic [23:0] LINE_MAX      = 24'hFFFFFF;
    localparam logic [23:0] LINE_FIRST    = 24'd1;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Token types
    localparam logic [2:0] TY_WORD   = 3'd0;
    localparam logic [2:0] TY_NUMBER = 3'd1;
    localparam logic [2:0] TY_STRING = 3'd2;
    localparam logic [2:0] TY_CHAR   = 3'd3;
    localparam logic [2:0] TY_DELIM  = 3'd4;
    localparam logic [2:0] TY_OPEN   = 3'd5;
    localparam logic [2:0] TY_CLOSE  = 3'd6;

    // Character codes
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // Result queue geometry
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  token_byte;
        logic [2:0]  token_type;
        logic [23:0] line;
        logic [6:0]  token_length;
        logic        last_result;
    } t_result;

    // Up to two result words from one source byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res1;
        t_result    res0;
    } t_scan_res;

    // Class of a byte outside quotes
    function automatic logic [2:0] unquoted_type(input logic [7:0] ch);
        logic [2:0] ty;
        ty = TY_WORD;
        if ((ch >= 8'h30 && ch <= 8'h39) || ch == CH_MINUS) ty = TY_NUMBER;
        else if (ch == CH_SEMI) ty = TY_DELIM;
        else if (ch == CH_LBRK) ty = TY_OPEN;
        else if (ch == CH_RBRK) ty = TY_CLOSE;
        return ty;
    endfunction

endpackage

// File: rtl/sbt_in_if.sv
// ----------------------------------------------------------------------------
// sbt_in_if: source byte channel
// Valid/ready channel carrying one source byte and the end-of-input flag.
// ----------------------------------------------------------------------------
interface sbt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

// File: rtl/sbt_out_if.sv
// ----------------------------------------------------------------------------
// sbt_out_if: token result channel
// Valid/ready channel carrying one token result word.
// ----------------------------------------------------------------------------
interface sbt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  token_byte;
    logic [2:0]  token_type;
    logic [23:0] line;
    logic [6:0]  token_length;
    logic        last_result;

    modport source (output valid, output kind, output token_byte, output token_type,
                    output line, output token_length, output last_result, input ready);
    modport sink   (input valid, input kind, input token_byte, input token_type,
                    input line, input token_length, input last_result, output ready);
endinterface

// File: rtl/sbt_scan.sv
// ----------------------------------------------------------------------------
// sbt_scan: tokenizer state and per-byte decision
// Holds quote, comment, token and line state and forms up to two result
// words for the registered source byte; state advances on i_fire.
// ----------------------------------------------------------------------------
module sbt_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_input,
    output sbt_pkg::t_scan_res o_res
);
    import sbt_pkg::*;

    logic        r_dq, r_sq, r_cmt, r_active, r_err;
    logic [2:0]  r_type;
    logic [6:0]  r_len;
    logic [23:0] r_line;

    logic        n_dq, n_sq, n_cmt, n_active, n_err;
    logic [2:0]  n_type;
    logic [6:0]  n_len;
    logic [23:0] n_line;

    // Decide results and next state for one byte
    always_comb begin
        logic       quoted;
        logic       brk;
        logic       start;
        logic [2:0] ntype;
        logic [2:0] cur_type;
        logic [6:0] cur_len;
        t_result    rb;

        quoted   = r_dq | r_sq;
        brk      = 1'b0;
        start    = 1'b0;
        ntype    = TY_WORD;
        cur_type = r_type;
        cur_len  = r_len;
        n_dq     = r_dq;
        n_sq     = r_sq;
        n_cmt    = r_cmt;
        n_active = r_active;
        n_err    = r_err;
        n_type   = r_type;
        n_len    = r_len;
        n_line   = r_line;
        o_res    = '0;
        rb       = '0;

        if (i_end_of_input) begin
            // Flush the open token and return to the start state
            if (r_active && !r_err) begin
                o_res.cnt               = 2'd1;
                o_res.res0.kind         = KIND_END;
                o_res.res0.token_type   = r_type;
                o_res.res0.line         = r_line;
                o_res.res0.token_length = r_len;
                o_res.res0.last_result  = 1'b1;
            end
            n_dq     = 1'b0;
            n_sq     = 1'b0;
            n_cmt    = 1'b0;
            n_active = 1'b0;
            n_err    = 1'b0;
            n_type   = TY_WORD;
            n_len    = '0;
            n_line   = LINE_FIRST;
        end else if (!r_err) begin
            if (i_data_byte == CH_SQUOTE) begin
                n_sq = ~r_sq;
            end else if (i_data_byte == CH_DQUOTE) begin
                n_dq = ~r_dq;
            end else if (i_data_byte == CH_COLON && !quoted) begin
                n_cmt = ~r_cmt;
            end else begin
                // Count unquoted newlines, saturating
                if (i_data_byte == CH_NL && !quoted && r_line < LINE_MAX)
                    n_line = r_line + 24'd1;
                rb.line = n_line;

                if (r_cmt && !r_dq) begin
                    // Drop commented bytes
                end else if ((i_data_byte != CH_SPACE && i_data_byte != CH_NL) || quoted) begin
                    if (r_dq)      ntype = TY_STRING;
                    else if (r_sq) ntype = TY_CHAR;
                    else           ntype = unquoted_type(i_data_byte);

                    brk   = r_active && (r_type != ntype) && (ntype != TY_STRING);
                    start = !r_active || brk;
                    if (start) begin
                        cur_type = ntype;
                        cur_len  = '0;
                    end
                    n_type = cur_type;

                    // Token end caused by a change of class
                    if (brk) begin
                        o_res.res0              = rb;
                        o_res.res0.kind         = KIND_END;
                        o_res.res0.token_type   = r_type;
                        o_res.res0.token_length = r_len;
                    end

                    rb.token_type = cur_type;
                    if (cur_len >= MAX_TOKEN_LEN) begin
                        rb.kind         = KIND_ERROR;
                        rb.token_length = cur_len;
                        n_err           = 1'b1;
                        n_active        = 1'b0;
                        n_len           = '0;
                    end else begin
                        rb.kind         = KIND_BYTE;
                        rb.token_byte   = i_data_byte;
                        rb.token_length = cur_len + 7'd1;
                        n_active        = 1'b1;
                        n_len           = cur_len + 7'd1;
                    end
                    rb.last_result = 1'b1;

                    if (brk) begin
                        o_res.cnt  = 2'd2;
                        o_res.res1 = rb;
                    end else begin
                        o_res.cnt  = 2'd1;
                        o_res.res0 = rb;
                    end
                end else if (r_active) begin
                    // Space or newline ends the token
                    o_res.cnt               = 2'd1;
                    o_res.res0              = rb;
                    o_res.res0.kind         = KIND_END;
                    o_res.res0.token_type   = r_type;
                    o_res.res0.token_length = r_len;
                    o_res.res0.last_result  = 1'b1;
                    n_active                = 1'b0;
                    n_len                   = '0;
                end
            end
        end
    end

    // Advance state when a byte is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dq     <= 1'b0;
            r_sq     <= 1'b0;
            r_cmt    <= 1'b0;
            r_active <= 1'b0;
            r_err    <= 1'b0;
            r_type   <= TY_WORD;
            r_len    <= '0;
            r_line   <= LINE_FIRST;
        end else if (i_fire) begin
            r_dq     <= n_dq;
            r_sq     <= n_sq;
            r_cmt    <= n_cmt;
            r_active <= n_active;
            r_err    <= n_err;
            r_type   <= n_type;
            r_len    <= n_len;
            r_line   <= n_line;
        end
    end

endmodule

// File: rtl/sbt_fifo.sv
// ----------------------------------------------------------------------------
// sbt_fifo: result queue
// Takes up to two result words per cycle and hands them out one word per
// cycle on the result channel while its receiver is ready.
// ----------------------------------------------------------------------------
module sbt_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sbt_pkg::t_scan_res i_res,
    output logic               o_space_ok,
    sbt_out_if.source          o_out
);
    import sbt_pkg::*;

    t_result                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]      r_wp, r_rp;
    logic [FIFO_AW:0]        r_cnt;
    logic [FIFO_AW-1:0]      n_wp, n_rp;
    logic [FIFO_AW:0]        n_cnt;
    logic [1:0]              push_cnt;
    logic                    pop;
    t_result                 head;

    assign push_cnt   = i_push ? i_res.cnt : 2'd0;
    assign pop        = o_out.valid && o_out.ready;
    assign o_space_ok = r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH - 2);

    // Pointer and fill count update
    always_comb begin
        n_wp  = r_wp + FIFO_AW'(push_cnt);
        n_rp  = r_rp + FIFO_AW'(pop);
        n_cnt = r_cnt + (FIFO_AW+1)'(push_cnt) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Write one or two words
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) r_mem[r_wp] <= i_res.res0;
        if (push_cnt == 2'd2) r_mem[r_wp + FIFO_AW'(1)] <= i_res.res1;
    end

    // Present the head word
    assign head               = r_mem[r_rp];
    assign o_out.valid        = r_cnt != '0;
    assign o_out.kind         = head.kind;
    assign o_out.token_byte   = head.token_byte;
    assign o_out.token_type   = head.token_type;
    assign o_out.line         = head.line;
    assign o_out.token_length = head.token_length;
    assign o_out.last_result  = head.last_result;

endmodule

// File: rtl/source_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// source_byte_tokenizer: top level of the source byte tokenizer
// Splits a source byte stream into typed token bytes and token-end words.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one source byte (or an end-of-input flag) per word; o_out
//   carries result words: token byte, token end with length and line, or
//   overflow error. last_result marks the final word caused by one input.
//   A byte is taken into an input register, decided against the tokenizer
//   state once the queue has room, and its words are written into a
//   four-entry result queue whose head word is presented on o_out.
//   Throughput is one byte per cycle while each byte gives at most one
//   word and o_out is not stalled; a byte that both ends a token and
//   starts a new one gives two words, and the queue's single read port
//   drains them one at a time.
//   The decision step runs only while the queue has room for two words, so
//   a stall on o_out backs up into the input register and then drops
//   i_in.ready; nothing is lost.
//   Synchronous reset clears the queue, the input register and all state;
//   the line counter restarts at one. End of input does the same to the
//   tokenizer state after flushing the open token.
// ----------------------------------------------------------------------------
module source_byte_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbt_in_if.sink    i_in,
    sbt_out_if.source o_out
);
    import sbt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_data_byte;
    logic       r_eoi;
    logic       fire;
    logic       space_ok;
    t_scan_res  scan_res;

    assign fire       = r_in_valid && space_ok;
    assign i_in.ready = !r_in_valid || fire;

    // Input register: hold the word until it is decided
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_data_byte <= i_in.data_byte;
            r_eoi       <= i_in.end_of_input;
        end
    end

    sbt_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_data_byte    (r_data_byte),
        .i_end_of_input (r_eoi),
        .o_res          (scan_res)
    );

    sbt_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (fire),
        .i_res      (scan_res),
        .o_space_ok (space_ok),
        .o_out      (o_out)
    );

endmodule
